// File: rtl/threshold_histogram_binning_unit_assert.svh
// Assertion macros shared by the histogram RTL.
`ifndef THRESHOLD_HISTOGRAM_BINNING_UNIT_ASSERT_SVH
`define THRESHOLD_HISTOGRAM_BINNING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define THB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define THB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define THB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define THB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/thb_pkg.sv
`default_nettype none

package thb_pkg;

	localparam int MAX_THRESHOLDS = 7;
	localparam int SAMPLE_WIDTH   = 32;
	localparam int COUNT_WIDTH    = 32;
	localparam int NUM_BUCKETS    = MAX_THRESHOLDS + 1;
	localparam int BUCKET_W       = $clog2(NUM_BUCKETS);
	localparam int TCOUNT_W       = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int QDEPTH         = 2;
	localparam int QPTR_W         = 1;
	localparam int QCNT_W         = 2;

	typedef logic [COUNT_WIDTH-1:0]         count_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [BUCKET_W-1:0]            bucket_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_BASE  = 3'd1;

	// classified item handed from front to back
	typedef struct packed {
		op_t     op;
		bucket_t bucket;
	} cmd_t;

	function automatic count_t sat_inc(input count_t c);
		sat_inc = (c == COUNT_MAX) ? c : c + count_t'(1);
	endfunction

endpackage

`default_nettype wire

// File: rtl/thb_front.sv
`default_nettype none

module thb_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	input  wire [thb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [thb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire [1:0]                     operation,
	input  wire thb_pkg::sample_t         sample,
	input  wire thb_pkg::bucket_t         bucket_select,
	output thb_pkg::cmd_t                 cmd
);
	import thb_pkg::*;

	logic [TCOUNT_W-1:0]                 tcount_q;
	sample_t                             thr_q [MAX_THRESHOLDS];
	logic [TCOUNT_W-1:0]                 n_used;
	logic [MAX_THRESHOLDS-1:0]           hit;
	bucket_t                             add_bucket;
	bucket_t                             rd_bucket;
	logic [CFG_IDX_W-1:0]                thr_wr_idx;

	assign thr_wr_idx = cfg_index - CFG_THRESHOLD_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= '0;
			for (int i = 0; i < MAX_THRESHOLDS; i++) begin
				thr_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == CFG_THRESHOLD_COUNT) begin
				tcount_q <= cfg_data[TCOUNT_W-1:0];
			end else begin
				thr_q[thr_wr_idx] <= sample_t'(cfg_data[SAMPLE_WIDTH-1:0]);
			end
		end
	end

	// count above the threshold bank acts as a full bank
	assign n_used = (tcount_q > TCOUNT_W'(MAX_THRESHOLDS)) ? TCOUNT_W'(MAX_THRESHOLDS)
		: tcount_q;

	always_comb begin
		for (int i = 0; i < MAX_THRESHOLDS; i++) begin
			hit[i] = (TCOUNT_W'(i) < n_used) && (sample < thr_q[i]);
		end
	end

	// first threshold above the sample wins; else the open-ended bucket
	always_comb begin
		add_bucket = bucket_t'(n_used);
		for (int i = MAX_THRESHOLDS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				add_bucket = bucket_t'(i);
			end
		end
	end

	assign rd_bucket = (bucket_select > bucket_t'(MAX_THRESHOLDS)) ? bucket_t'(MAX_THRESHOLDS)
		: bucket_select;

	always_comb begin
		cmd.op = op_t'(operation);
		case (op_t'(operation))
			OP_ADD:  cmd.bucket = add_bucket;
			OP_READ: cmd.bucket = rd_bucket;
			default: cmd.bucket = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/thb_queue.sv
`default_nettype none
`include "threshold_histogram_binning_unit_assert.svh"

module thb_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  thb_pkg::cmd_t push_cmd,
	output logic          not_full,
	input  wire           pop,
	output thb_pkg::cmd_t pop_cmd,
	output logic          not_empty
);
	import thb_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_full  = (count_q != QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`THB_ASSERT_IMPLIES(a_q_no_overflow, clk, arst_n, push, not_full)
	`THB_ASSERT_IMPLIES(a_q_no_underflow, clk, arst_n, pop, not_empty)
	`THB_ASSERT_IMPLIES(a_q_count_range, clk, arst_n, 1'b1, count_q <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

// File: rtl/thb_back.sv
`default_nettype none
`include "threshold_histogram_binning_unit_assert.svh"

module thb_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	input  thb_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  wire              out_ready,
	output thb_pkg::bucket_t bucket_index,
	output thb_pkg::count_t  bucket_count,
	output thb_pkg::count_t  total_count,
	output logic             saturated
);
	import thb_pkg::*;

	count_t  cnt_q [NUM_BUCKETS];
	count_t  total_q;
	logic    out_valid_q;
	bucket_t bucket_index_q;
	count_t  bucket_count_q;
	count_t  total_count_q;
	logic    saturated_q;

	count_t  cur_cnt;
	count_t  inc_cnt;
	count_t  inc_tot;
	bucket_t res_idx;
	count_t  res_cnt;
	count_t  res_tot;

	// output register frees up when its item is taken
	assign cmd_pop = cmd_valid && (!out_valid_q || out_ready);

	assign cur_cnt = cnt_q[cmd.bucket];
	assign inc_cnt = sat_inc(cur_cnt);
	assign inc_tot = sat_inc(total_q);

	always_comb begin
		case (cmd.op)
			OP_ADD: begin
				res_idx = cmd.bucket;
				res_cnt = inc_cnt;
				res_tot = inc_tot;
			end
			OP_READ: begin
				res_idx = cmd.bucket;
				res_cnt = cur_cnt;
				res_tot = total_q;
			end
			default: begin
				res_idx = '0;
				res_cnt = '0;
				res_tot = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd_pop) begin
			case (cmd.op)
				OP_ADD: begin
					cnt_q[cmd.bucket] <= inc_cnt;
					total_q           <= inc_tot;
				end
				OP_CLEAR: begin
					total_q <= '0;
					for (int i = 0; i < NUM_BUCKETS; i++) begin
						cnt_q[i] <= '0;
					end
				end
				default: total_q <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bucket_index_q <= res_idx;
			bucket_count_q <= res_cnt;
			total_count_q  <= res_tot;
			saturated_q    <= (res_cnt == COUNT_MAX) || (res_tot == COUNT_MAX);
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_index_q;
	assign bucket_count = bucket_count_q;
	assign total_count  = total_count_q;
	assign saturated    = saturated_q;

	`THB_ASSERT_IMPLIES(a_bucket_le_total, clk, arst_n, out_valid_q, bucket_count_q <= total_count_q)
	`THB_ASSERT_NEXT(a_clear_zeroes, clk, arst_n, cmd_pop && (cmd.op == OP_CLEAR), total_q == '0)
	`THB_ASSERT_NEXT(a_add_counts, clk, arst_n, cmd_pop && (cmd.op == OP_ADD), total_q != '0)

endmodule

`default_nettype wire

// File: rtl/threshold_histogram_binning_unit.sv
`default_nettype none

// Threshold histogram: an add item sorts its signed sample into the first bucket whose
// threshold is above it (or the last, open-ended bucket) and bumps that bucket and the
// total, both saturating; a read item returns one bucket with the total; a clear zeroes
// all counters. Every item yields one result. The front compares the sample against all
// thresholds at once and writes the bucket into a two-entry queue; the back updates the
// counters and loads the output register. One item per cycle is sustained while
// out_ready is high. Thresholds are to be written through the cfg port only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
module threshold_histogram_binning_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [thb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [thb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire [1:0]                     operation,
	input  wire thb_pkg::sample_t         sample,
	input  wire thb_pkg::bucket_t         bucket_select,
	output logic                          out_valid,
	input  wire                           out_ready,
	output thb_pkg::bucket_t              bucket_index,
	output thb_pkg::count_t               bucket_count,
	output thb_pkg::count_t               total_count,
	output logic                          saturated
);
	import thb_pkg::*;

	cmd_t front_cmd;
	cmd_t q_cmd;
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;

	assign cfg_ready = 1'b1;
	assign in_ready  = q_not_full;

	thb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.sample        (sample),
		.bucket_select (bucket_select),
		.cmd           (front_cmd)
	);

	thb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && q_not_full),
		.push_cmd  (front_cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.pop_cmd   (q_cmd),
		.not_empty (q_not_empty)
	);

	thb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (q_cmd),
		.cmd_pop      (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.bucket_count (bucket_count),
		.total_count  (total_count),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire
